[hw/rtl/gradient_edge_magnitude_3x3_macros.svh]
// Assertion macros for the RTL; included by the controller.
`ifndef GRADIENT_EDGE_MAGNITUDE_3X3_MACROS_SVH
`define GRADIENT_EDGE_MAGNITUDE_3X3_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GEM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GEM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/gem_pkg.sv]
package gem_pkg;

    // Configuration port
    localparam int CFG_W     = 13;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_GRADIENT_KIND  = 2'd3;

    // Mask set codes
    localparam logic [1:0] KIND_SOBEL   = 2'd0;
    localparam logic [1:0] KIND_PREWITT = 2'd1;
    localparam logic [1:0] KIND_SCHARR  = 2'd2;

    // Datapath widths
    localparam int PIX_W   = 8;
    localparam int GRAD_W  = 13;
    localparam int ABS_W   = 12;
    localparam int SQ_W    = 24;
    localparam int SUM_W   = 25;
    localparam int RAD_W   = 16;
    localparam int ROOT_W  = 8;
    localparam int THR_W   = 9;

    localparam logic [ROOT_W-1:0] MAG_LIMIT    = 8'd255;
    localparam logic [SUM_W-1:0]  MAG_LIMIT_SQ = 25'd65025;

    typedef logic signed [GRAD_W-1:0] grad_t;

    // Controller to datapath
    typedef struct packed {
        logic load_px;   // latch pixel, read both line buffers
        logic shift;     // advance window, write lines, step counters
        logic grad;      // form both gradients
        logic square;    // square both gradients
        logic sum;       // add squares, start root
        logic load_out;  // fill the output register
    } gem_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic interior;
        logic root_done;
    } gem_stat_t;

    // Corner weight: 3 for Scharr, 1 otherwise
    function automatic grad_t wt_corner(logic [1:0] kind, grad_t x);
        grad_t r;
        unique case (kind)
            KIND_SCHARR: r = x + (x <<< 1);
            default:     r = x;
        endcase
        return r;
    endfunction

    // Edge weight: 2 for Sobel, 1 for Prewitt, 10 for Scharr
    function automatic grad_t wt_edge(logic [1:0] kind, grad_t x);
        grad_t r;
        unique case (kind)
            KIND_PREWITT: r = x;
            KIND_SCHARR:  r = (x <<< 3) + (x <<< 1);
            default:      r = x <<< 1;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/gem_isqrt.sv]
module gem_isqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [gem_pkg::RAD_W-1:0]    radicand,
    output logic                         done,
    output logic [gem_pkg::ROOT_W-1:0]   root
);
    import gem_pkg::*;

    localparam int REM_W  = ROOT_W + 3;
    localparam int STEP_W = $clog2(ROOT_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;

    // One result bit per cycle: bring down two radicand bits, try 4*root+1
    always_comb begin
        rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        if (rem_sh >= trial) begin
            rem_next  = rem_sh - trial;
            root_next = {root_reg[ROOT_W-2:0], 1'b1};
        end else begin
            rem_next  = rem_sh;
            root_next = {root_reg[ROOT_W-2:0], 1'b0};
        end
    end

    // Sequence the iterations
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(ROOT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Hold operands and partial results
    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

[hw/rtl/gem_dp.sv]
module gem_dp #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [gem_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [gem_pkg::CFG_W-1:0]       cfg_data,
    input  logic [gem_pkg::PIX_W-1:0]       s_gray_pixel,
    input  gem_pkg::gem_cmd_t               cmd,
    output gem_pkg::gem_stat_t              stat,
    output logic [gem_pkg::ROOT_W-1:0]      m_edge_value,
    output logic                            m_last_of_frame
);
    import gem_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WX = (CW + 1 > 12) ? CW + 1 : 12;
    localparam int HX = (RW + 1 > 13) ? RW + 1 : 13;

    // Configuration registers
    logic [11:0]      fw_reg;
    logic [12:0]      fh_reg;
    logic [THR_W-1:0] thr_reg;
    logic [1:0]       kind_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg   <= 12'd640;
            fh_reg   <= 13'd480;
            thr_reg  <= '0;
            kind_reg <= KIND_SOBEL;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:    fw_reg   <= cfg_data[11:0];
                REG_FRAME_HEIGHT:   fh_reg   <= cfg_data[12:0];
                REG_EDGE_THRESHOLD: thr_reg  <= cfg_data[THR_W-1:0];
                REG_GRADIENT_KIND:  kind_reg <= cfg_data[1:0];
            endcase
        end
    end

    // Raster position
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [WX-1:0] col_inc;
    logic [HX-1:0] row_inc;
    logic          row_end;
    logic          frame_end;

    always_comb begin
        col_inc   = WX'(col_reg) + 1'b1;
        row_inc   = HX'(row_reg) + 1'b1;
        row_end   = (col_inc >= WX'(fw_reg)) || (col_inc >= WX'(MAX_WIDTH));
        frame_end = row_end &&
                    ((row_inc >= HX'(fh_reg)) || (row_inc >= HX'(MAX_HEIGHT)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cmd.shift) begin
            if (row_end) begin
                col_reg <= '0;
                row_reg <= frame_end ? '0 : row_inc[RW-1:0];
            end else begin
                col_reg <= col_inc[CW-1:0];
            end
        end
    end

    // Status back to the controller
    logic root_done;

    always_comb begin
        stat.interior  = (row_reg >= RW'(2)) && (col_reg >= CW'(2));
        stat.root_done = root_done;
    end

    // Line buffers: read on pixel load, write back on shift
    logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
    logic [PIX_W-1:0] up_rd_reg;
    logic [PIX_W-1:0] mid_rd_reg;
    logic [PIX_W-1:0] px_reg;
    logic             last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_px) begin
            up_rd_reg <= upper_mem[col_reg];
        end
        if (cmd.shift) begin
            upper_mem[col_reg] <= mid_rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_px) begin
            mid_rd_reg <= middle_mem[col_reg];
        end
        if (cmd.shift) begin
            middle_mem[col_reg] <= px_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_px) begin
            px_reg <= s_gray_pixel;
        end
        if (cmd.shift) begin
            last_reg <= frame_end;
        end
    end

    // 3x3 window, column 0 oldest, row 0 oldest
    logic [PIX_W-1:0] win_reg [9];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else if (cmd.shift) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r*3]     <= win_reg[r*3 + 1];
                win_reg[r*3 + 1] <= win_reg[r*3 + 2];
            end
            win_reg[2] <= up_rd_reg;
            win_reg[5] <= mid_rd_reg;
            win_reg[8] <= px_reg;
        end
    end

    // Gradients
    grad_t d02, d68, d35, d06, d28, d17;
    grad_t gh_next, gv_next;
    grad_t gh_reg, gv_reg;

    always_comb begin
        d02 = $signed(GRAD_W'(win_reg[0])) - $signed(GRAD_W'(win_reg[2]));
        d68 = $signed(GRAD_W'(win_reg[6])) - $signed(GRAD_W'(win_reg[8]));
        d35 = $signed(GRAD_W'(win_reg[3])) - $signed(GRAD_W'(win_reg[5]));
        d06 = $signed(GRAD_W'(win_reg[0])) - $signed(GRAD_W'(win_reg[6]));
        d28 = $signed(GRAD_W'(win_reg[2])) - $signed(GRAD_W'(win_reg[8]));
        d17 = $signed(GRAD_W'(win_reg[1])) - $signed(GRAD_W'(win_reg[7]));
        gh_next = wt_corner(kind_reg, d02 + d68) + wt_edge(kind_reg, d35);
        gv_next = wt_corner(kind_reg, d06 + d28) + wt_edge(kind_reg, d17);
    end

    always_ff @(posedge aclk) begin
        if (cmd.grad) begin
            gh_reg <= gh_next;
            gv_reg <= gv_next;
        end
    end

    // Squares of magnitudes
    logic [GRAD_W-1:0] gh_neg, gv_neg;
    logic [ABS_W-1:0]  gh_abs, gv_abs;
    logic [SQ_W-1:0]   sqh_reg, sqv_reg;

    always_comb begin
        gh_neg = -gh_reg;
        gv_neg = -gv_reg;
        gh_abs = gh_reg[GRAD_W-1] ? gh_neg[ABS_W-1:0] : gh_reg[ABS_W-1:0];
        gv_abs = gv_reg[GRAD_W-1] ? gv_neg[ABS_W-1:0] : gv_reg[ABS_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.square) begin
            sqh_reg <= gh_abs * gh_abs;
            sqv_reg <= gv_abs * gv_abs;
        end
    end

    // Sum, saturation check and root
    logic [SUM_W-1:0]  sum_sq;
    logic              sat_reg;
    logic [ROOT_W-1:0] root;

    assign sum_sq = SUM_W'(sqh_reg) + SUM_W'(sqv_reg);

    always_ff @(posedge aclk) begin
        if (cmd.sum) begin
            sat_reg <= sum_sq > MAG_LIMIT_SQ;
        end
    end

    gem_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sum),
        .radicand (sum_sq[RAD_W-1:0]),
        .done     (root_done),
        .root     (root)
    );

    // Output register: clamp, then threshold
    logic [ROOT_W-1:0] edge_reg;
    logic              out_last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            if (sat_reg) begin
                edge_reg <= MAG_LIMIT;
            end else if (THR_W'(root) < thr_reg) begin
                edge_reg <= '0;
            end else begin
                edge_reg <= root;
            end
            out_last_reg <= last_reg;
        end
    end

    assign m_edge_value    = edge_reg;
    assign m_last_of_frame = out_last_reg;

endmodule

[hw/rtl/gem_ctrl.sv]
`include "gradient_edge_magnitude_3x3_macros.svh"

module gem_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output gem_pkg::gem_cmd_t   cmd,
    input  gem_pkg::gem_stat_t  stat
);
    import gem_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_GRAD = 3'd2;
    localparam logic [2:0] ST_SQR  = 3'd3;
    localparam logic [2:0] ST_SUM  = 3'd4;
    localparam logic [2:0] ST_ROOT = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_valid_reg;
    logic       accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    // Sequence one item through the datapath
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load_px = 1'b1;
                    state_next  = ST_RD;
                end
            end
            ST_RD: begin
                cmd.shift  = 1'b1;
                state_next = stat.interior ? ST_GRAD : ST_IDLE;
            end
            ST_GRAD: begin
                cmd.grad   = 1'b1;
                state_next = ST_SQR;
            end
            ST_SQR: begin
                cmd.square = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (stat.root_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    `GEM_ASSERT_NOW(a_no_overwrite, aclk, aresetn, cmd.load_out, !m_valid_reg || m_ready, "result overwritten before taken")
    `GEM_ASSERT_NEXT(a_accept_reads, aclk, aresetn, accept, state_reg == ST_RD, "accepted item not sent to line read")
    `GEM_ASSERT_NOW(a_root_in_wait, aclk, aresetn, stat.root_done, state_reg == ST_ROOT, "root finished outside its wait state")

endmodule

[hw/rtl/gradient_edge_magnitude_3x3.sv]
// Once accepted, an interior pixel passes states RD, GRAD, SQR, SUM, ROOT and EMIT;
// a border pixel passes RD alone. One item at a time: no new pixel is taken until the
// last is through; EMIT waits while the result side stalls. The 8-step bit-serial root
// runs in ROOT. Reset (aresetn low, synchronous): counters, window and handshakes
// clear, registers return to 640x480, threshold 0, Sobel; line buffers are not cleared.
module gradient_edge_magnitude_3x3 #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [gem_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [gem_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [gem_pkg::PIX_W-1:0]       s_gray_pixel,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [gem_pkg::ROOT_W-1:0]      m_edge_value,
    output logic                            m_last_of_frame
);
    import gem_pkg::*;

    gem_cmd_t  cmd;
    gem_stat_t stat;

    gem_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    gem_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_gray_pixel    (s_gray_pixel),
        .cmd             (cmd),
        .stat            (stat),
        .m_edge_value    (m_edge_value),
        .m_last_of_frame (m_last_of_frame)
    );

endmodule

[tb/gradient_edge_magnitude_3x3_tb.sv]
`timescale 1ns / 100ps

module gradient_edge_magnitude_3x3_tb;
    import gem_pkg::*;

    localparam int MAX_COLS      = 2048;
    localparam int MAX_ROWS      = 4096;
    localparam int WIDTH_W       = 12;
    localparam int HEIGHT_W      = 13;
    localparam int KIND_W        = 2;
    localparam int RANDOM_PIXELS = 1600;
    localparam int DRAIN_CYCLES  = 24;
    localparam int CYCLE_LIMIT   = 5_000_000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [ROOT_W-1:0] edge_value;
        logic              last_of_frame;
    } edge_result_t;

    typedef enum {STYLE_RANDOM, STYLE_SOFT, STYLE_BINARY, STYLE_RAMP} pixel_style_t;

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 cfg_wr_en       = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index       = '0;
    logic [CFG_W-1:0]     cfg_data        = '0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic [PIX_W-1:0]     s_gray_pixel    = '0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic [ROOT_W-1:0]    m_edge_value;
    logic                 m_last_of_frame;

    // Predictor copy of the registers and of the block state
    logic [WIDTH_W-1:0]   frame_width_q   = 12'd640;
    logic [HEIGHT_W-1:0]  frame_height_q  = 13'd480;
    logic [THR_W-1:0]     threshold_q     = '0;
    logic [KIND_W-1:0]    kind_q          = KIND_SOBEL;
    logic [PIX_W-1:0]     upper_row [MAX_COLS];
    logic [PIX_W-1:0]     middle_row [MAX_COLS];
    logic [PIX_W-1:0]     window [9];
    int                   frame_col       = 0;
    int                   frame_row       = 0;

    logic [PIX_W-1:0]     pending_pixels [$];
    edge_result_t         expected_edges [$];
    int                   pixels_sent     = 0;
    int                   pixels_taken    = 0;
    int                   error_count     = 0;
    int                   cycle_count     = 0;
    int                   burst_left      = 0;
    int                   gap_left        = 0;
    int                   ready_hold      = 0;

    gradient_edge_magnitude_3x3 dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_gray_pixel    (s_gray_pixel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_edge_value    (m_edge_value),
        .m_last_of_frame (m_last_of_frame)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int eff_width();
        return (frame_width_q > MAX_COLS) ? MAX_COLS : int'(frame_width_q);
    endfunction

    function automatic int eff_height();
        return (frame_height_q > MAX_ROWS) ? MAX_ROWS : int'(frame_height_q);
    endfunction

    // Clamped, thresholded gradient magnitude of the current window
    function automatic logic [ROOT_W-1:0] edge_magnitude();
        int corner, side, gh, gv, sum_sq, root, trial, b;
        case (kind_q)
            KIND_PREWITT: begin
                corner = 1;
                side   = 1;
            end
            KIND_SCHARR: begin
                corner = 3;
                side   = 10;
            end
            default: begin
                corner = 1;
                side   = 2;
            end
        endcase
        gh = corner * (int'(window[0]) - int'(window[2]))
           + side   * (int'(window[3]) - int'(window[5]))
           + corner * (int'(window[6]) - int'(window[8]));
        gv = corner * (int'(window[0]) - int'(window[6]))
           + side   * (int'(window[1]) - int'(window[7]))
           + corner * (int'(window[2]) - int'(window[8]));
        sum_sq = gh * gh + gv * gv;
        if (sum_sq > int'(MAG_LIMIT_SQ)) return MAG_LIMIT;
        // Build the floor root one bit at a time, MSB first
        root = 0;
        for (b = ROOT_W - 1; b >= 0; b--) begin
            trial = root | (1 << b);
            if (trial * trial <= sum_sq) root = trial;
        end
        if (root < int'(threshold_q)) return '0;
        return root[ROOT_W-1:0];
    endfunction

    // Advance the predictor by one accepted pixel
    task automatic predict_pixel(input logic [PIX_W-1:0] px);
        int col, ew, eh, i;
        bit row_end, frame_end;
        edge_result_t res;
        ew        = eff_width();
        eh        = eff_height();
        col       = (frame_col < MAX_COLS) ? frame_col : MAX_COLS - 1;
        row_end   = (frame_col + 1 >= ew);
        frame_end = row_end && (frame_row + 1 >= eh);
        for (i = 0; i < 3; i++) begin
            window[i*3]     = window[i*3 + 1];
            window[i*3 + 1] = window[i*3 + 2];
        end
        window[2]       = upper_row[col];
        window[5]       = middle_row[col];
        window[8]       = px;
        upper_row[col]  = middle_row[col];
        middle_row[col] = px;
        if (frame_row >= 2 && col >= 2) begin
            res.edge_value    = edge_magnitude();
            res.last_of_frame = frame_end;
            expected_edges.push_back(res);
        end
        if (row_end) begin
            frame_col = 0;
            frame_row = frame_end ? 0 : frame_row + 1;
        end else begin
            frame_col = frame_col + 1;
        end
    endtask

    // Pixels until the frame in progress closes under the current sizes
    function automatic int pixels_left_in_frame();
        int c, r, n, ew, eh;
        bit row_end, frame_end;
        ew = eff_width();
        eh = eff_height();
        c  = frame_col;
        r  = frame_row;
        n  = 0;
        do begin
            n++;
            row_end   = (c + 1 >= ew);
            frame_end = row_end && (r + 1 >= eh);
            if (row_end) begin
                c = 0;
                r = r + 1;
            end else begin
                c = c + 1;
            end
        end while (!frame_end);
        return n;
    endfunction

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT) $display("%s", msg);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_W-1:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:    frame_width_q  = val[WIDTH_W-1:0];
            REG_FRAME_HEIGHT:   frame_height_q = val[HEIGHT_W-1:0];
            REG_EDGE_THRESHOLD: threshold_q    = val[THR_W-1:0];
            default:            kind_q         = val[KIND_W-1:0];
        endcase
    endtask

    task automatic write_config(input int w, input int h, input int thr, input int kind);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_EDGE_THRESHOLD, thr);
        write_reg(REG_GRADIENT_KIND, kind);
    endtask

    // Hold until every pixel is taken and every result is back, then let the block settle
    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_pixels.size() != 0 || pixels_sent != pixels_taken
               || expected_edges.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic push_pixels(input int n, input pixel_style_t style);
        int i, base, stride;
        logic [PIX_W-1:0] px;
        base   = $urandom_range(0, 240);
        stride = $urandom_range(1, 40);
        for (i = 0; i < n; i++) begin
            case (style)
                STYLE_SOFT:   px = PIX_W'(base + $urandom_range(0, 15));
                STYLE_BINARY: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                STYLE_RAMP:   px = PIX_W'(base + i * stride);
                default:      px = PIX_W'($urandom_range(0, 255));
            endcase
            pending_pixels.push_back(px);
        end
    endtask

    // One setting: write it, send the rest of the frame plus whole frames or a cut-short part, drain
    task automatic run_phase(input int w, input int h, input int thr, input int kind,
                             input int extra_frames, input bit cut_short,
                             input pixel_style_t style, output int n_pixels);
        int frame_size;
        write_config(w, h, thr, kind);
        frame_size = ((eff_width() < 1) ? 1 : eff_width())
                   * ((eff_height() < 1) ? 1 : eff_height());
        n_pixels = pixels_left_in_frame() + extra_frames * frame_size;
        if (cut_short && n_pixels > 1) n_pixels = $urandom_range(1, n_pixels - 1);
        push_pixels(n_pixels, style);
        wait_idle();
    endtask

    function automatic int pick_threshold();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 255;
            2:       return $urandom_range(256, 511);
            5:       return $urandom_range(0, 511);
            default: return $urandom_range(0, 80);
        endcase
    endfunction

    function automatic int pick_size(input int lo, input int hi);
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 2);
        return $urandom_range(lo, hi);
    endfunction

    // Accept pixels and run them through the predictor
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            predict_pixel(s_gray_pixel);
            pixels_taken <= pixels_taken + 1;
        end
    end

    // Drive pixels in bursts with random gaps; hold each until taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || pixels_sent == pixels_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_pixels.size() > 0) begin
                s_valid      <= 1'b1;
                s_gray_pixel <= pending_pixels.pop_front();
                pixels_sent  <= pixels_sent + 1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    case ($urandom_range(0, 3))
                        0:       gap_left = 0;
                        3:       gap_left = $urandom_range(7, 30);
                        default: gap_left = $urandom_range(1, 6);
                    endcase
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Stall the result side in runs of random length
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (ready_hold > 0) begin
            ready_hold--;
        end else if ($urandom_range(0, 3) == 0) begin
            m_ready    <= 1'b0;
            ready_hold = $urandom_range(1, 20);
        end else begin
            m_ready    <= 1'b1;
            ready_hold = $urandom_range(1, 60);
        end
    end

    // Compare each result with the oldest expected one
    always @(posedge aclk) begin : check_results
        edge_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_edges.size() == 0) begin
                note_failure($sformatf("result with nothing expected: value %0d last %0b",
                                       m_edge_value, m_last_of_frame));
            end else begin
                want = expected_edges.pop_front();
                if (m_edge_value !== want.edge_value
                    || m_last_of_frame !== want.last_of_frame) begin
                    note_failure($sformatf(
                        "edge mismatch: expected value %0d last %0b, got value %0d last %0b",
                        want.edge_value, want.last_of_frame, m_edge_value, m_last_of_frame));
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("gradient_edge_magnitude_3x3 verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int i, n, w, h, random_pixels;
        bit mid;
        for (i = 0; i < MAX_COLS; i++) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
        for (i = 0; i < 9; i++) window[i] = '0;
        random_pixels = 0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Sobel on a hard vertical step: saturates
        write_config(3, 3, 0, KIND_SOBEL);
        for (i = 0; i < 9; i++) pending_pixels.push_back((i % 3 == 2) ? 8'hFF : 8'h00);
        wait_idle();
        // Prewitt on a gentle ramp: plain root
        write_config(3, 3, 0, KIND_PREWITT);
        for (i = 0; i < 9; i++) pending_pixels.push_back(PIX_W'(10 * (i % 3 + 1)));
        wait_idle();
        // Scharr with a threshold past the clamp: forced to zero
        write_config(3, 3, 300, KIND_SCHARR);
        for (i = 0; i < 9; i++) pending_pixels.push_back(PIX_W'(i % 3));
        wait_idle();

        // Small random frames; a phase may stop mid-frame, then only shrink the width
        while (random_pixels < RANDOM_PIXELS) begin
            mid = (frame_col != 0 || frame_row != 0);
            if (!mid) w = pick_size(3, 12);
            else if ($urandom_range(0, 1) == 1) w = int'(frame_width_q);
            else w = $urandom_range(0, eff_width());
            h = pick_size(3, 7);
            run_phase(w, h, pick_threshold(), $urandom_range(0, 3), $urandom_range(0, 2),
                      ($urandom_range(0, 3) == 0), pixel_style_t'($urandom_range(0, 3)), n);
            random_pixels += n;
        end

        if (error_count == 0) begin
            $display("gradient_edge_magnitude_3x3 verification clean");
        end else begin
            $display("gradient_edge_magnitude_3x3 verification failed");
        end
        $finish;
    end

endmodule

[gradient_edge_magnitude_3x3.f]
+incdir+hw/rtl
hw/rtl/gem_pkg.sv
hw/rtl/gem_isqrt.sv
hw/rtl/gem_dp.sv
hw/rtl/gem_ctrl.sv
hw/rtl/gradient_edge_magnitude_3x3.sv
tb/gradient_edge_magnitude_3x3_tb.sv
